>>> hw/rtl/fesc_pkg.sv
`timescale 1ns / 1ps
package fesc_pkg;

  localparam int HeaderBytes     = 20;
  localparam int DigestBytes     = 32;
  localparam int FrameMin        = HeaderBytes + DigestBytes;
  localparam logic [20:0] MaxPayloadReset = 21'd1048576;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_DIG_MISM  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUT_BYTE,
    S_RND_RD,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_LEN,
    S_CMP,
    S_STATUS,
    S_CLEAR
  } fsm_t;

  localparam logic [31:0] ShaInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hw/rtl/frame_envelope_sha256_check_core.sv
`timescale 1ns / 1ps
// Frame envelope checker with SHA-256 payload digest.
// Input channel (in_valid/in_ready): one frame byte per request, in_frame_last
// on the final byte. Bytes 0..19 are the little-endian header, 20..51 the
// declared digest, the rest payload.
// Output channel (out_valid/out_ready): each payload byte is forwarded as a
// kind-0 request (provisional); the last byte adds a kind-1 status request
// with the verdict and header fields.
// Header and digest bytes are stored at accept. A payload byte passes through
// accept, buffer read-modify-write and forward, plus the output handshake; the
// byte that completes a 64-byte block also waits for the round unit (one
// SHA-256 round per cycle). Frame end runs padding, with one or two extra
// compressions when the length check passes and none otherwise, then the
// status request.
// cfg_we/cfg_wdata write max_payload_bytes (low 21 bits); used at next status.
// Reset (synchronous, rst_n low) clears position, header, digest and chain
// value; the 16-word block buffer is not cleared.
// A stalled receiver holds the output register; in_ready stays low meanwhile.
module frame_envelope_sha256_check_core #(
  parameter logic [20:0] MAX_PAYLOAD_RESET = fesc_pkg::MaxPayloadReset
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_data,
  output logic [2:0]  out_frame_status,
  output logic [31:0] out_frame_magic,
  output logic [15:0] out_frame_version,
  output logic [15:0] out_message_type,
  output logic [31:0] out_declared_length,
  output logic [63:0] out_timestamp_ms,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata
);

  fesc_pkg::fsm_t state_r, state_nxt;
  logic [20:0]  max_pl_r;
  logic [31:0]  pos_r;
  logic [159:0] hdr_r;
  logic [255:0] exp_r;
  logic [31:0]  bits_r;
  logic [7:0]   byte_r;
  logic         last_r;
  logic [2:0]   status_r;
  logic         pad_two_r;   // padding needs two blocks

  logic         hw_en;
  logic [3:0]   hw_idx, hr_idx;
  logic [31:0]  hw_data, hr_data;
  logic         h_go, h_busy, h_chain_rst;
  logic [255:0] h_dig;

  fesc_hash u_hash (
    .clk(clk), .rst_n(rst_n), .wr_en(hw_en), .wr_idx(hw_idx), .wr_data(hw_data),
    .rd_idx(hr_idx), .rd_data(hr_data), .compress(h_go),
    .chain_reset(h_chain_rst), .busy(h_busy), .digest(h_dig)
  );

  logic [5:0]  fill;
  logic [1:0]  bsel;
  logic        acc;
  assign fill = bits_r[8:3];
  assign bsel = fill[1:0];
  assign acc  = in_valid && in_ready;

  // saturating position after this byte
  logic [31:0] pos_inc;
  assign pos_inc = (&pos_r) ? pos_r : pos_r + 32'd1;

  logic [31:0] declared;
  assign declared = hdr_r[95:64];

  logic [32:0] want_total;
  assign want_total = 33'(declared) + 33'(fesc_pkg::FrameMin);

  // byte merge for read-modify-write of buffer word
  function automatic logic [31:0] merge(input logic [31:0] w, input logic [1:0] s,
                                        input logic [7:0] b);
    logic [31:0] r;
    r = (s == 2'd0) ? 32'd0 : w;
    case (s)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  logic [3:0] clr_r, clr_nxt;   // padding word cursor
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    hw_en         = 1'b0;
    hw_idx        = fill[5:2];
    hw_data       = '0;
    hr_idx        = fill[5:2];
    h_go          = 1'b0;
    h_chain_rst   = 1'b0;
    out_valid_nxt = out_valid && !out_ready;
    clr_nxt       = clr_r;
    case (state_r)
      fesc_pkg::S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (acc) begin
          if (pos_r >= 32'(fesc_pkg::FrameMin)) begin
            state_nxt = fesc_pkg::S_RND_RD;
          end else if (in_frame_last) begin
            state_nxt = fesc_pkg::S_STATUS;
          end
        end
      end
      fesc_pkg::S_RND_RD: begin
        // read data arrives now; write merged byte, emit payload request once the output register is free
        hw_en   = 1'b1;
        hw_data = merge(hr_data, bsel, byte_r);
        if (!out_valid || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = fesc_pkg::S_OUT_BYTE;
        end
      end
      fesc_pkg::S_OUT_BYTE: begin
        if (fill == 6'd0) begin
          h_go      = 1'b1;
          state_nxt = fesc_pkg::S_ROUND;
        end else begin
          state_nxt = last_r ? fesc_pkg::S_STATUS : fesc_pkg::S_IDLE;
        end
      end
      fesc_pkg::S_ROUND: begin
        if (!h_busy) state_nxt = last_r ? fesc_pkg::S_STATUS : fesc_pkg::S_IDLE;
      end
      fesc_pkg::S_STATUS: begin
        // length checks; on pass run padding
        if (pos_r >= 32'(fesc_pkg::FrameMin) && declared <= 32'(max_pl_r) &&
            33'(pos_r) == want_total) begin
          state_nxt = fesc_pkg::S_PAD;
        end else begin
          state_nxt = fesc_pkg::S_CMP;
        end
      end
      fesc_pkg::S_PAD: begin
        // write 0x80 into current word
        hw_en   = 1'b1;
        hw_data = merge(hr_data, bsel, 8'h80);
        clr_nxt = fill[5:2] + 4'd1;
        state_nxt = fesc_pkg::S_CLEAR;
        if (fill[5:2] == 4'd15) begin
          if (pad_two_r) begin
            h_go = 1'b0;
            state_nxt = fesc_pkg::S_ADD;
          end
        end
      end
      fesc_pkg::S_CLEAR: begin
        // zero remaining words; in the final block the length word goes to 15
        hw_en   = 1'b1;
        hw_idx  = clr_r;
        hw_data = '0;
        if (!pad_two_r && clr_r == 4'd15) hw_data = bits_r;
        if (clr_r == 4'd15) state_nxt = fesc_pkg::S_ADD;
        clr_nxt = clr_r + 4'd1;
      end
      fesc_pkg::S_ADD: begin
        h_go = 1'b1;
        state_nxt = fesc_pkg::S_LEN;
      end
      fesc_pkg::S_LEN: begin
        if (!h_busy) begin
          if (pad_two_r) begin
            // word 0 cleared here, the rest in S_CLEAR
            state_nxt = fesc_pkg::S_CLEAR;
            clr_nxt   = 4'd1;
            hw_en = 1'b1; hw_idx = 4'd0; hw_data = '0;
          end else begin
            state_nxt = fesc_pkg::S_CMP;
          end
        end
      end
      fesc_pkg::S_CMP: begin
        if (!out_valid || out_ready) begin
          out_valid_nxt = 1'b1;
          h_chain_rst   = 1'b1;
          state_nxt     = fesc_pkg::S_IDLE;
        end
      end
      default: state_nxt = fesc_pkg::S_IDLE;
    endcase
  end

  logic [2:0] verdict;
  always_comb begin
    if (pos_r < 32'(fesc_pkg::FrameMin))   verdict = fesc_pkg::ST_SHORT;
    else if (declared > 32'(max_pl_r))     verdict = fesc_pkg::ST_TOO_LARGE;
    else if (33'(pos_r) != want_total)     verdict = fesc_pkg::ST_LEN_MISM;
    else if (h_dig != exp_r)               verdict = fesc_pkg::ST_DIG_MISM;
    else                                   verdict = fesc_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fesc_pkg::S_IDLE;
      max_pl_r  <= MAX_PAYLOAD_RESET;
      pos_r     <= '0;
      hdr_r     <= '0;
      exp_r     <= '0;
      bits_r    <= '0;
      out_valid <= 1'b0;
      last_r    <= 1'b0;
      clr_r     <= '0;
      pad_two_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
      clr_r     <= clr_nxt;
      if (cfg_we) max_pl_r <= cfg_wdata;
      if (acc) begin
        byte_r <= in_frame_byte;
        last_r <= in_frame_last;
        pos_r  <= pos_inc;
        if (pos_r < 32'(fesc_pkg::HeaderBytes)) begin
          hdr_r[pos_r[4:0]*8 +: 8] <= in_frame_byte;
        end else if (pos_r < 32'(fesc_pkg::FrameMin)) begin
          exp_r[255 - (pos_r[5:0] - 6'd20)*8 -: 8] <= in_frame_byte;
        end
      end
      if (state_r == fesc_pkg::S_RND_RD && state_nxt == fesc_pkg::S_OUT_BYTE) begin
        bits_r <= bits_r + 32'd8;
      end
      if (state_r == fesc_pkg::S_STATUS) pad_two_r <= (fill >= 6'd56);
      if (state_r == fesc_pkg::S_LEN && !h_busy && pad_two_r) pad_two_r <= 1'b0;
      if (state_r == fesc_pkg::S_CMP && state_nxt == fesc_pkg::S_IDLE) begin
        pos_r  <= '0;
        hdr_r  <= '0;
        exp_r  <= '0;
        bits_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == fesc_pkg::S_RND_RD && state_nxt == fesc_pkg::S_OUT_BYTE) begin
      out_item_kind       <= 1'b0;
      out_payload_data    <= byte_r;
      out_frame_status    <= '0;
      out_frame_magic     <= '0;
      out_frame_version   <= '0;
      out_message_type    <= '0;
      out_declared_length <= '0;
      out_timestamp_ms    <= '0;
    end else if (state_r == fesc_pkg::S_CMP && state_nxt == fesc_pkg::S_IDLE) begin
      out_item_kind       <= 1'b1;
      out_payload_data    <= '0;
      out_frame_status    <= verdict;
      out_frame_magic     <= hdr_r[31:0];
      out_frame_version   <= hdr_r[47:32];
      out_message_type    <= hdr_r[63:48];
      out_declared_length <= hdr_r[95:64];
      out_timestamp_ms    <= hdr_r[159:96];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == fesc_pkg::S_IDLE) else $error("accept while busy");
  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fesc_pkg::S_CMP && state_nxt == fesc_pkg::S_IDLE |=> pos_r == 32'd0)
    else $error("frame state not cleared");

endmodule

>>> hw/rtl/fesc_hash.sv
`timescale 1ns / 1ps
// SHA-256 round unit: message schedule kept in a 16-word window memory
// (the block buffer), one round per cycle.
module fesc_hash (
  input  logic                clk,
  input  logic                rst_n,
  // word write into block buffer
  input  logic                wr_en,
  input  logic [3:0]          wr_idx,
  input  logic [31:0]         wr_data,
  input  logic [3:0]          rd_idx,
  output logic [31:0]         rd_data,
  input  logic                compress,   // start compression of buffer
  input  logic                chain_reset,
  output logic                busy,
  output logic [255:0]        digest
);

  logic [31:0] buf_mem [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [6:0]  round_r, round_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] w_t;

  always_ff @(posedge clk) begin
    rd_data <= buf_mem[rd_idx];
  end

  // schedule: window word t%16 is w[t]; for t>=16 compute and write back
  logic [31:0] wm16, wm15, wm7, wm2, s0, s1, wnew;
  logic [3:0]  ri;
  assign ri   = round_r[3:0];
  assign wm16 = buf_mem[ri];
  assign wm15 = buf_mem[ri + 4'd1];
  assign wm7  = buf_mem[ri + 4'd9];
  assign wm2  = buf_mem[ri + 4'd14];
  assign s0   = fesc_pkg::rotr(wm15, 7) ^ fesc_pkg::rotr(wm15, 18) ^ (wm15 >> 3);
  assign s1   = fesc_pkg::rotr(wm2, 17) ^ fesc_pkg::rotr(wm2, 19) ^ (wm2 >> 10);
  assign wnew = wm16 + s0 + wm7 + s1;
  assign w_t  = (round_r < 7'd16) ? wm16 : wnew;

  logic [31:0] e1, ch, t1, a0, mj;
  assign e1 = fesc_pkg::rotr(v_r[4], 6) ^ fesc_pkg::rotr(v_r[4], 11) ^
              fesc_pkg::rotr(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1 = v_r[7] + e1 + ch + fesc_pkg::sha_k(round_r[5:0]) + w_t;
  assign a0 = fesc_pkg::rotr(v_r[0], 2) ^ fesc_pkg::rotr(v_r[0], 13) ^
              fesc_pkg::rotr(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);

  always_comb begin
    busy_nxt  = busy_r;
    round_nxt = round_r;
    if (compress && !busy_r) begin
      busy_nxt  = 1'b1;
      round_nxt = '0;
    end else if (busy_r) begin
      round_nxt = round_r + 7'd1;
      if (round_r == 7'd64) begin
        busy_nxt  = 1'b0;
        round_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && round_r < 7'd64 && round_r >= 7'd16) begin
      buf_mem[ri] <= wnew;
    end else if (wr_en) begin
      buf_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || chain_reset) begin
      for (int i = 0; i < 8; i++) h_r[i] <= fesc_pkg::ShaInit[i];
    end else if (compress && !busy_r) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (busy_r && round_r < 7'd64) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + a0 + mj;
    end else if (busy_r) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign busy = busy_r;
  always_comb begin
    for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = h_r[i];
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> round_r <= 7'd64) else $error("round overrun");
  a_idle_round: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> round_r == 7'd0) else $error("round not cleared");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(compress)) else $error("spurious start");

endmodule
